@@ src/rotation_matrix_to_quaternion_top_defines.svh @@
// Assertion macros for the rotation matrix to quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`ifndef SYNTH
`define RMQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RMQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RMQ_ASSERT_IMP(lbl, ante, cons)
`define RMQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ src/rmq_pkg.sv @@
// Shared constants and types of the rotation matrix to quaternion block.
package rmq_pkg;
	localparam int FRAC_BITS = 14;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int SAT       = (ONE > 32767) ? 32767 : ONE;
	localparam int U_W       = 17;
	localparam int V_W       = U_W + FRAC_BITS;
	localparam int R_W       = (V_W + 1) / 2;
	localparam int N_W       = 17;
	localparam int Q_W       = 15;
	localparam int NUM_W     = N_W + FRAC_BITS + 1;
	localparam int D_W       = R_W + 1;
	localparam int SQ_LAT    = R_W;
	localparam int DIV_LAT   = Q_W + 1;

	typedef enum logic [1:0] {BR_W, BR_X, BR_Y, BR_Z} branch_t;

	typedef struct packed {
		branch_t            br;
		logic [2:0]         neg;
		logic [2:0][N_W-1:0] mag;
	} side_t;

	typedef struct packed {
		branch_t        br;
		logic [2:0]     neg;
		logic [R_W-1:0] r;
	} tail_t;
endpackage

@@ src/rmq_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage.
module rmq_sqrt_pipe (
	input  logic                 clk,
	input  logic                 en,
	input  logic [rmq_pkg::U_W-1:0] u,
	output logic [rmq_pkg::R_W-1:0] r
);
	import rmq_pkg::*;

	logic [V_W-1:0] rem_s  [SQ_LAT];
	logic [R_W-1:0] root_s [SQ_LAT];

	for (genvar i = 0; i < SQ_LAT; i++) begin : g_stage
		localparam int B = R_W - 1 - i;
		logic [V_W-1:0] rem_in;
		logic [R_W-1:0] root_in;
		logic [V_W+1:0] trial;
		if (i == 0) begin : g_first
			assign rem_in  = {u, FRAC_BITS'(0)};
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
		end
		assign trial = ((V_W+2)'(root_in) << (B + 1)) + ((V_W+2)'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if ({2'b00, rem_in} >= trial) begin
					rem_s[i]  <= V_W'({2'b00, rem_in} - trial);
					root_s[i] <= root_in | (R_W'(1) << B);
				end else begin
					rem_s[i]  <= rem_in;
					root_s[i] <= root_in;
				end
			end
		end
	end

	assign r = root_s[SQ_LAT-1];
endmodule

@@ src/rmq_div_pipe.sv @@
// Pipelined rounded divide of a magnitude by twice the root, saturated.
module rmq_div_pipe (
	input  logic                    clk,
	input  logic                    en,
	input  logic [rmq_pkg::N_W-1:0] mag,
	input  logic [rmq_pkg::R_W-1:0] r,
	output logic [rmq_pkg::Q_W-1:0] q
);
	import rmq_pkg::*;

	logic [NUM_W-1:0] num;
	logic [D_W-1:0]   d;
	logic             zero;

	logic [NUM_W-1:0] rem_s [DIV_LAT];
	logic [D_W-1:0]   d_s   [DIV_LAT];
	logic [Q_W-1:0]   qb_s  [DIV_LAT];
	logic             ovf_s [DIV_LAT];
	logic             clr_s [DIV_LAT];

	// Adding r before the divide by 2r rounds half away from zero.
	assign num  = {1'b0, mag, FRAC_BITS'(0)} + NUM_W'(r);
	assign d    = {r, 1'b0};
	assign zero = (r == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			d_s[0]   <= d;
			qb_s[0]  <= '0;
			clr_s[0] <= zero && (mag == '0);
			ovf_s[0] <= zero ? (mag != '0) : (num >= {d, Q_W'(0)});
		end
	end

	for (genvar j = 1; j < DIV_LAT; j++) begin : g_step
		localparam int K = Q_W - j;
		logic [NUM_W-1:0] trial;
		assign trial = NUM_W'(d_s[j-1]) << K;
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[j]   <= d_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				clr_s[j] <= clr_s[j-1];
				if (rem_s[j-1] >= trial) begin
					rem_s[j] <= rem_s[j-1] - trial;
					qb_s[j]  <= qb_s[j-1] | (Q_W'(1) << K);
				end else begin
					rem_s[j] <= rem_s[j-1];
					qb_s[j]  <= qb_s[j-1];
				end
			end
		end
	end

	always_comb begin
		if (clr_s[DIV_LAT-1]) begin
			q = '0;
		end else if (ovf_s[DIV_LAT-1] || (qb_s[DIV_LAT-1] > Q_W'(SAT))) begin
			q = Q_W'(SAT);
		end else begin
			q = qb_s[DIV_LAT-1];
		end
	end
endmodule

@@ src/rotation_matrix_to_quaternion_top.sv @@
// Every stage is a register; a beat passes decode, square root, divide and output.
// Throughput: one matrix per cycle unless the output stalls; no unit is shared.
// Depth is set by the 16-stage square root followed by the 16-stage divide.
// A stall at the output freezes the whole pipeline in place.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers keep no reset.
module rotation_matrix_to_quaternion_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each, from bit 0 up
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// qw, qx, qy, qz, 16 bits each, from bit 0 up
	output logic [63:0]  m_axis_tdata
);
	import rmq_pkg::*;
	`include "rotation_matrix_to_quaternion_top_defines.svh"

	// One enable moves every stage; it is low only when the output beat is stuck.
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Decode stage: trace, branch choice, radicand and off-diagonal numerators.
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	assign {m22, m21, m20, m12, m11, m10, m02, m01, m00} = s_axis_tdata;

	logic signed [18:0] tr, u_sel;
	logic signed [17:0] n_a, n_b, n_c;
	branch_t            br;
	side_t              side_d;
	logic [U_W-1:0]     u_d;

	always_comb begin
		tr = 19'(m00) + 19'(m11) + 19'(m22);
		if (tr > 0) begin
			br    = BR_W;
			u_sel = tr + 19'(ONE);
			n_a   = 18'(m21) - 18'(m12);
			n_b   = 18'(m02) - 18'(m20);
			n_c   = 18'(m10) - 18'(m01);
		end else if ((m00 > m11) && (m00 > m22)) begin
			br    = BR_X;
			u_sel = 19'(ONE) + 19'(m00) - 19'(m11) - 19'(m22);
			n_a   = 18'(m21) - 18'(m12);
			n_b   = 18'(m01) + 18'(m10);
			n_c   = 18'(m02) + 18'(m20);
		end else if (m11 > m22) begin
			br    = BR_Y;
			u_sel = 19'(ONE) + 19'(m11) - 19'(m00) - 19'(m22);
			n_a   = 18'(m02) - 18'(m20);
			n_b   = 18'(m01) + 18'(m10);
			n_c   = 18'(m12) + 18'(m21);
		end else begin
			br    = BR_Z;
			u_sel = 19'(ONE) + 19'(m22) - 19'(m00) - 19'(m11);
			n_a   = 18'(m10) - 18'(m01);
			n_b   = 18'(m02) + 18'(m20);
			n_c   = 18'(m12) + 18'(m21);
		end
		// A radicand at or below zero comes from a non-rotation matrix; it is clamped.
		u_d         = (u_sel <= 0) ? '0 : u_sel[U_W-1:0];
		side_d.br   = br;
		side_d.neg  = {n_c[17], n_b[17], n_a[17]};
		side_d.mag[0] = n_a[17] ? N_W'(-n_a) : N_W'(n_a);
		side_d.mag[1] = n_b[17] ? N_W'(-n_b) : N_W'(n_b);
		side_d.mag[2] = n_c[17] ? N_W'(-n_c) : N_W'(n_c);
	end

	logic           vld_s1;
	side_t          side_s1;
	logic [U_W-1:0] u_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d;
			u_s1    <= u_d;
		end
	end

	// Square root stages; the side data rides alongside in a matching delay line.
	logic [R_W-1:0] r_sq;
	logic           sq_vld_s  [SQ_LAT];
	side_t          sq_side_s [SQ_LAT];

	rmq_sqrt_pipe u_sqrt (
		.clk (clk),
		.en  (en),
		.u   (u_s1),
		.r   (r_sq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SQ_LAT; i++) begin
				sq_vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			sq_vld_s[0] <= vld_s1;
			for (int i = 1; i < SQ_LAT; i++) begin
				sq_vld_s[i] <= sq_vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_side_s[0] <= side_s1;
			for (int i = 1; i < SQ_LAT; i++) begin
				sq_side_s[i] <= sq_side_s[i-1];
			end
		end
	end

	// Three dividers, one per off-diagonal component, all fed the same root.
	logic [Q_W-1:0] q_lane [3];
	for (genvar l = 0; l < 3; l++) begin : g_lane
		rmq_div_pipe u_div (
			.clk (clk),
			.en  (en),
			.mag (sq_side_s[SQ_LAT-1].mag[l]),
			.r   (r_sq),
			.q   (q_lane[l])
		);
	end

	tail_t tail_d;
	logic  dv_vld_s  [DIV_LAT];
	tail_t dv_tail_s [DIV_LAT];

	assign tail_d.br  = sq_side_s[SQ_LAT-1].br;
	assign tail_d.neg = sq_side_s[SQ_LAT-1].neg;
	assign tail_d.r   = r_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				dv_vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			dv_vld_s[0] <= sq_vld_s[SQ_LAT-1];
			for (int i = 1; i < DIV_LAT; i++) begin
				dv_vld_s[i] <= dv_vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_tail_s[0] <= tail_d;
			for (int i = 1; i < DIV_LAT; i++) begin
				dv_tail_s[i] <= dv_tail_s[i-1];
			end
		end
	end

	// Output stage: diagonal term is r/2 rounded half up, then everything is placed.
	tail_t              tl;
	logic [R_W:0]       half;
	logic signed [15:0] diag, lane [3];
	logic signed [15:0] qw_d, qx_d, qy_d, qz_d;

	always_comb begin
		tl   = dv_tail_s[DIV_LAT-1];
		half = ({1'b0, tl.r} + (R_W+1)'(1)) >> 1;
		diag = (half > (R_W+1)'(SAT)) ? 16'(SAT) : 16'(half);
		for (int l = 0; l < 3; l++) begin
			lane[l] = tl.neg[l] ? -$signed(16'(q_lane[l])) : $signed(16'(q_lane[l]));
		end
		case (tl.br)
			BR_W: begin
				qw_d = diag;    qx_d = lane[0]; qy_d = lane[1]; qz_d = lane[2];
			end
			BR_X: begin
				qw_d = lane[0]; qx_d = diag;    qy_d = lane[1]; qz_d = lane[2];
			end
			BR_Y: begin
				qw_d = lane[0]; qx_d = lane[1]; qy_d = diag;    qz_d = lane[2];
			end
			default: begin
				qw_d = lane[0]; qx_d = lane[1]; qy_d = lane[2]; qz_d = diag;
			end
		endcase
	end

	logic        out_vld_q;
	logic [63:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld_s[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {qz_d, qy_d, qx_d, qw_d};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// The qw and qz components of a delivered beat lie within the saturation range.
	`RMQ_ASSERT_IMP(a_qw_range, m_axis_tvalid, ($signed(m_axis_tdata[15:0]) <= 16'(SAT)) && ($signed(m_axis_tdata[15:0]) >= -$signed(16'(SAT))))
	`RMQ_ASSERT_IMP(a_qz_range, m_axis_tvalid, ($signed(m_axis_tdata[63:48]) <= 16'(SAT)) && ($signed(m_axis_tdata[63:48]) >= -$signed(16'(SAT))))
	// While the output is stalled, the decode, last square root and last divide valid bits do not move.
	`RMQ_ASSERT_NXT(a_stall_freeze, !en, $stable(vld_s1) && $stable(sq_vld_s[SQ_LAT-1]) && $stable(dv_vld_s[DIV_LAT-1]))
endmodule
